// ===== rtl/core/cti_pkg.sv =====
// Shared types and constants for the calibration table interpolator.
// No dependencies.
package cti_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int CMDQ_DEPTH     = 2;   // beats held between front and back
  localparam int FRAC_BITS      = 8;
  localparam int DIV_STEPS      = 24;  // quotient magnitude always fits 24 bits

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                kind;
    logic [4:0]         slot;
    logic signed [15:0] p_raw;
    logic signed [15:0] p_val;
    logic signed [15:0] raw;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEARCH,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN,
    ST_PUT
  } state_t;

endpackage

// ===== rtl/core/calibration_table_interpolator.sv =====
// Calibration table interpolator top level: config register, front end,
// back end. Depends on cti_pkg, cti_front, cti_back.
//
// Piecewise linear calibration over up to MAX_POINTS (raw, value) points.
// A load beat writes one point and yields no result; a convert beat yields
// one 24-bit result with 8 fractional bits. A two-beat command queue takes
// input while the back end works. The back end handles one command at a
// time: a load is written from the idle state; a convert scans points (one
// per cycle from the point memory) and, when it interpolates, runs one
// multiply, the divider and the final add, then waits until the result
// register is empty or being popped. Points never loaded read back as
// undefined; load every slot below table_size before converting.
// table_size is to be written only while the block is idle; the block
// itself does not enforce this. Values above MAX_POINTS act as
// MAX_POINTS.
module calibration_table_interpolator #(
  parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [4:0]         point_index,
  input  logic signed [15:0] point_raw,
  input  logic signed [15:0] point_val,
  input  logic signed [15:0] raw_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] calibrated_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);
  import cti_pkg::*;

  logic [5:0] table_size;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;
  logic       res_vld;

  assign cfg_ready = 1'b1;
  assign empty     = !res_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  cti_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .point_index (point_index),
    .point_raw   (point_raw),
    .point_val   (point_val),
    .raw_value   (raw_value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  cti_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .table_size (table_size),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .res_vld    (res_vld),
    .res        (calibrated_value),
    .pop        (pop)
  );

endmodule

// ===== rtl/core/cti_front.sv =====
// Front end: takes input beats, drops loads aimed past the table, and
// queues commands for the back end. Depends on cti_pkg.
module cti_front #(
  parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [4:0]         point_index,
  input  logic signed [15:0] point_raw,
  input  logic signed [15:0] point_val,
  input  logic signed [15:0] raw_value,
  output logic               cmd_valid,
  output cti_pkg::cmd_t      cmd,
  input  logic               cmd_take
);
  import cti_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             new_cmd;
  logic             acc;
  logic             drop;
  logic             enq;

  always_comb begin
    new_cmd.kind  = op_t'(opcode);
    new_cmd.slot  = point_index;
    new_cmd.p_raw = point_raw;
    new_cmd.p_val = point_val;
    new_cmd.raw   = raw_value;
  end

  assign full      = (count == CNT_W'(CMDQ_DEPTH));
  assign acc       = push && !full;
  // a load at or past MAX_POINTS is swallowed here
  assign drop      = (op_t'(opcode) == OP_LOAD) && (32'(point_index) >= 32'(MAX_POINTS));
  assign enq       = acc && !drop;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !cmd_take) begin
        count <= count + 1'b1;
      end else if (!enq && cmd_take) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CMDQ_DEPTH))
    else $error("command queue overfilled");

  a_no_take_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> count != '0)
    else $error("back end took from empty command queue");

  a_drop_no_fill: assert property (@(posedge clk) disable iff (rst)
    (acc && drop && !cmd_take) |=> count == $past(count))
    else $error("dropped load changed queue fill");

endmodule

// ===== rtl/core/cti_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Numerator is scaled by 2^FRAC_BITS internally. Depends on cti_pkg.
module cti_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  num,
  input  logic [15:0]                  den,
  output logic                         done,
  output logic [cti_pkg::DIV_STEPS-1:0] quo
);
  import cti_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [15:0]          rem;
  logic [DIV_STEPS-1:0] sh;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic [16:0]          trial;
  logic [16:0]          diff;
  logic                 ge;

  assign trial = {rem, sh[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // upper numerator bits are already below den, so only the low bits are walked
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[31:16];
      sh  <= {num[15:0], {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem <= ge ? diff[15:0] : trial[15:0];
      sh  <= {sh[DIV_STEPS-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/cti_back.sv =====
// Back end: point memory, sequential search, multiply and divide sequencer,
// and the result register. Depends on cti_pkg and cti_div.
module cti_back #(
  parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         table_size,
  input  logic               cmd_valid,
  input  cti_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               res_vld,
  output logic signed [23:0] res,
  input  logic               pop
);
  import cti_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LAST  = MAX_POINTS - 1;

  logic [31:0]        pt_mem [MAX_POINTS];
  logic [31:0]        rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;

  state_t             state;
  state_t             state_next;

  logic [IDX_W-1:0]   chk;
  logic [CNT_W-1:0]   n_lim;
  logic [CNT_W-1:0]   n_eff;
  logic signed [15:0] raw;
  logic signed [15:0] lo_raw;
  logic signed [15:0] lo_val;
  logic signed [15:0] hi_val;
  logic signed [16:0] dr;
  logic signed [16:0] dv;
  logic [15:0]        den;
  logic signed [33:0] prod;
  logic signed [33:0] prod_neg;
  logic               neg;
  logic [23:0]        res_calc;

  logic signed [15:0] rd_raw;
  logic signed [15:0] rd_val;
  logic               hit;
  logic               last;
  logic               put_fire;
  logic               div_start;
  logic [31:0]        div_num;
  logic               div_done;
  logic [DIV_STEPS-1:0] quo;

  assign rd_raw   = rd_data[31:16];
  assign rd_val   = rd_data[15:0];
  assign hit      = (raw < rd_raw);
  assign last     = (CNT_W'(chk) == n_lim - CNT_W'(1));
  assign n_eff    = (32'(table_size) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(table_size);
  assign prod_neg = -prod;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[IDX_W'(cmd.slot)] <= {cmd.p_raw, cmd.p_val};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= pt_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == OP_LOAD) begin
            state_next = ST_IDLE;
          end else if (table_size == '0) begin
            state_next = ST_PUT;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (hit) begin
          if (chk == '0 || rd_raw == lo_raw) begin
            state_next = ST_PUT;
          end else begin
            state_next = ST_MUL;
          end
        end else if (last) begin
          state_next = ST_PUT;
        end
      end
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: state_next = ST_PUT;
      ST_PUT: begin
        if (put_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_take  = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    put_fire  = 1'b0;
    div_num   = prod[31:0];
    case (state)
      ST_IDLE: begin
        cmd_take = cmd_valid;
        mem_we   = cmd_valid && (cmd.kind == OP_LOAD);
      end
      ST_SEARCH: begin
        // fetch the next point while this one is compared
        rd_addr = (chk == IDX_W'(LAST)) ? '0 : chk + 1'b1;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        div_num   = prod[33] ? prod_neg[31:0] : prod[31:0];
      end
      ST_PUT: begin
        put_fire = !res_vld || pop;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      res_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (put_fire) begin
        res_vld <= 1'b1;
      end else if (pop) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        raw      <= cmd.raw;
        n_lim    <= n_eff;
        chk      <= '0;
        res_calc <= {cmd.raw, {FRAC_BITS{1'b0}}};
      end
      ST_SEARCH: begin
        res_calc <= {rd_val, {FRAC_BITS{1'b0}}};
        if (hit) begin
          hi_val <= rd_val;
          dr     <= {rd_raw[15], rd_raw} - {raw[15], raw};
          dv     <= {rd_val[15], rd_val} - {lo_val[15], lo_val};
          den    <= rd_raw[15:0] - lo_raw[15:0];
        end else begin
          lo_raw <= rd_raw;
          lo_val <= rd_val;
          chk    <= chk + 1'b1;
        end
      end
      ST_MUL: begin
        prod <= dr * dv;
      end
      ST_DSTART: begin
        neg <= prod[33];
      end
      ST_FIN: begin
        res_calc <= neg ? {hi_val, {FRAC_BITS{1'b0}}} + quo
                        : {hi_val, {FRAC_BITS{1'b0}}} - quo;
      end
      ST_PUT: begin
        if (put_fire) begin
          res <= res_calc;
        end
      end
      default: begin
      end
    endcase
  end

  cti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> CNT_W'(chk) < n_lim)
    else $error("search index past table size");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DSTART |-> den != '0)
    else $error("interpolation with zero raw span");

endmodule
